[design/oitw_pkg.sv]
// ----------------------------------------------------------------------------
// oitw_pkg: shared types, constants and helpers of the fragment weight block
// Register indexes, reset values, stage counts and the exp2 factor table.
// ----------------------------------------------------------------------------
package oitw_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CfgWeightMode    = 3'd0,
    CfgMinWeight     = 3'd1,
    CfgMaxWeight     = 3'd2,
    CfgAlphaExponent = 3'd3,
    CfgDepthExponent = 3'd4,
    CfgDepthScale    = 3'd5,
    CfgNearClamp     = 3'd6,
    CfgFarClamp      = 3'd7
  } cfg_idx_e;

  // Weight mode that bypasses the depth path.
  localparam logic [1:0] ModeAlphaRef = 2'd0;

  // Reset values of the registers.
  localparam logic [1:0]  RstWeightMode    = 2'd2;
  localparam logic [23:0] RstMinWeight     = 24'd41;
  localparam logic [23:0] RstMaxWeight     = 24'd12288000;
  localparam logic [15:0] RstAlphaExponent = 16'd12288;
  localparam logic [15:0] RstDepthExponent = 16'd12288;
  localparam logic [15:0] RstDepthScale    = 16'd58982;
  localparam logic [23:0] RstNearClamp     = 24'd2048;
  localparam logic [23:0] RstFarClamp      = 24'd2097152;

  // Fallback depth range (8.0 and 8192.0 in Q16.8).
  localparam logic [23:0] DefNear = 24'd2048;
  localparam logic [23:0] DefFar  = 24'd2097152;

  // Minimum opacity contribution, Q0.16.
  localparam logic [16:0] MinOpacityQ16 = 17'd655;

  // Stage counts.
  localparam int DivSteps = 16;
  localparam int LogLat   = 17;
  localparam int ExpLat   = 18;
  localparam int PipeLat  = 1 + DivSteps + 1 + LogLat + 1 + ExpLat + 3;

  // Sideband that travels with every item.
  typedef struct packed {
    logic        valid;
    logic [12:0] w_alpha;
  } side_t;

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factor 2^(2^-i) in Q1.30, each the truncated root of the one before.
  function automatic logic [30:0] exp2_factor(int i);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int k = 1; k < i; k++) begin
      r = isqrt64(r << 30);
    end
    return r[30:0];
  endfunction

endpackage

[design/oitw_log2.sv]
// ----------------------------------------------------------------------------
// oitw_log2: pipelined base-2 logarithm
// Leading-one normalization, then one squaring per stage gives one fraction
// bit. Input Q16 (nonzero, below 2^17), output signed Q16.
// ----------------------------------------------------------------------------
module oitw_log2 (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [16:0]        x_i,
  output logic signed [21:0] l_o
);

  logic [30:0] m_q [oitw_pkg::LogLat];
  logic [4:0]  p_q [oitw_pkg::LogLat];
  logic [15:0] f_q [oitw_pkg::LogLat];

  logic [4:0]  p_d;
  logic [46:0] m_wide;
  logic [5:0]  int_part;

  // Position of the leading one.
  always_comb begin
    p_d = '0;
    for (int b = 0; b < 17; b++) begin
      if (x_i[b]) p_d = 5'(b);
    end
  end

  assign m_wide = {30'b0, x_i} << (5'd30 - p_d);

  // Normalize the mantissa into [1,2) in Q1.30.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m_wide[30:0];
      p_q[0] <= p_d;
      f_q[0] <= '0;
    end
  end

  // One squaring and one fraction bit per stage.
  for (genvar k = 1; k < oitw_pkg::LogLat; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] s;
    assign sq = 62'(m_q[k-1]) * 62'(m_q[k-1]);
    assign s  = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k] <= s[31] ? s[31:1] : s[30:0];
        p_q[k] <= p_q[k-1];
        f_q[k] <= {f_q[k-1][14:0], s[31]};
      end
    end
  end

  assign int_part = {1'b0, p_q[oitw_pkg::LogLat-1]} - 6'd16;
  assign l_o      = $signed({int_part, f_q[oitw_pkg::LogLat-1]});

endmodule

[design/oitw_exp2.sv]
// ----------------------------------------------------------------------------
// oitw_exp2: pipelined base-2 exponential
// Each fraction bit selects a constant factor in one stage; the last stage
// scales by the integer part. Input signed Q16, output Q16.
// ----------------------------------------------------------------------------
module oitw_exp2 (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [25:0] y_i,
  output logic [32:0]        r_o
);

  localparam int Steps = oitw_pkg::ExpLat - 1;

  logic [30:0]       v_q [Steps];
  logic signed [9:0] n_q [Steps];
  logic [15:0]       f_q [Steps];
  logic [32:0]       r_q;

  // Split into integer and fraction part.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= 31'h4000_0000;
      n_q[0] <= y_i[25:16];
      f_q[0] <= y_i[15:0];
    end
  end

  // Multiply in the factor of one fraction bit per stage.
  for (genvar k = 1; k < Steps; k++) begin : g_mul
    localparam logic [30:0] Fac = oitw_pkg::exp2_factor(k);
    logic [61:0] pr;
    assign pr = 62'(v_q[k-1]) * 62'(Fac);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= f_q[k-1][16-k] ? pr[60:30] : v_q[k-1];
        n_q[k] <= n_q[k-1];
        f_q[k] <= f_q[k-1];
      end
    end
  end

  // Scale by the integer part, truncating.
  logic signed [10:0] sh;
  logic [10:0]        neg;
  logic [32:0]        r_d;

  assign sh  = 11'sd14 - 11'(n_q[Steps-1]);
  assign neg = 11'(-sh);

  always_comb begin
    if (sh >= 11'sd31) begin
      r_d = '0;
    end else if (!sh[10]) begin
      r_d = 33'(v_q[Steps-1] >> sh[4:0]);
    end else begin
      r_d = {2'b0, v_q[Steps-1]} << neg[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_q <= r_d;
  end

  assign r_o = r_q;

endmodule

[design/oit_fragment_weight.sv]
// ----------------------------------------------------------------------------
// oit_fragment_weight: blend weight for weighted blended transparency
// Opacity and view depth in, one Q12.12 weight out per fragment.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  input   | in_valid_i, in_stall_o, opacity_i,   | into block
//          | view_depth_i                         |
//  output  | out_valid_o, out_stall_i, weight_o   | out of block
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i      | into block
//
// One beat is accepted every cycle while the output is not stalled.
// The pipeline holds the 16 divider steps, 16 squaring stages of the
// logarithm and 16 factor stages of the exponential.
// Reset clears all valid bits and loads the register defaults.
// A stalled output beat freezes the whole pipeline, including the input.
// ----------------------------------------------------------------------------
module oit_fragment_weight (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] opacity_i,
  input  logic [23:0] view_depth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] weight_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int Lat = oitw_pkg::PipeLat;
  localparam int Div = oitw_pkg::DivSteps;

  // Configuration registers.
  logic [1:0]  mode_q;
  logic [23:0] min_q, max_q, near_q, far_q;
  logic [15:0] aexp_q, zexp_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= oitw_pkg::RstWeightMode;
      min_q   <= oitw_pkg::RstMinWeight;
      max_q   <= oitw_pkg::RstMaxWeight;
      aexp_q  <= oitw_pkg::RstAlphaExponent;
      zexp_q  <= oitw_pkg::RstDepthExponent;
      scale_q <= oitw_pkg::RstDepthScale;
      near_q  <= oitw_pkg::RstNearClamp;
      far_q   <= oitw_pkg::RstFarClamp;
    end else if (cfg_we_i) begin
      case (oitw_pkg::cfg_idx_e'(cfg_idx_i))
        oitw_pkg::CfgWeightMode:    mode_q  <= cfg_data_i[1:0];
        oitw_pkg::CfgMinWeight:     min_q   <= cfg_data_i;
        oitw_pkg::CfgMaxWeight:     max_q   <= cfg_data_i;
        oitw_pkg::CfgAlphaExponent: aexp_q  <= cfg_data_i[15:0];
        oitw_pkg::CfgDepthExponent: zexp_q  <= cfg_data_i[15:0];
        oitw_pkg::CfgDepthScale:    scale_q <= cfg_data_i[15:0];
        oitw_pkg::CfgNearClamp:     near_q  <= cfg_data_i;
        oitw_pkg::CfgFarClamp:      far_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: moves unless a finished beat waits at the output.
  oitw_pkg::side_t side_q [Lat];
  logic            en;

  assign en         = !side_q[Lat-1].valid || !out_stall_i;
  assign in_stall_o = !en;

  // Sideband shift line.
  logic [14:0] a_d;
  always_comb begin
    if (opacity_i[15])                a_d = '0;
    else if (opacity_i > 16'd16384)   a_d = 15'd16384;
    else                              a_d = opacity_i[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lat; k++) side_q[k] <= '0;
    end else if (en) begin
      side_q[0].valid   <= in_valid_i;
      side_q[0].w_alpha <= a_d[14:2];
      for (int k = 1; k < Lat; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Stage 0: opacity base, depth range and divider operands.
  logic [23:0] zn, zf;
  logic [17:0] t10;
  logic [14:0] tc;
  assign zn  = (far_q > near_q) ? near_q : oitw_pkg::DefNear;
  assign zf  = (far_q > near_q) ? far_q  : oitw_pkg::DefFar;
  assign t10 = 18'(a_d) * 18'd10;
  assign tc  = (t10 > 18'd16384) ? 15'd16384 : t10[14:0];

  logic [23:0] rem_q [Div+1];
  logic [23:0] d_q   [Div+1];
  logic [15:0] q_q   [Div+1];
  logic        lo_q  [Div+1];
  logic        hi_q  [Div+1];
  logic [16:0] ba_q  [Div+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= view_depth_i - zn;
      d_q[0]   <= zf - zn;
      q_q[0]   <= '0;
      lo_q[0]  <= view_depth_i <= zn;
      hi_q[0]  <= view_depth_i >= zf;
      ba_q[0]  <= {tc, 2'b0} + oitw_pkg::MinOpacityQ16;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 1; k <= Div; k++) begin : g_div
    logic [24:0] r2;
    logic        ge;
    assign r2 = {rem_q[k-1], 1'b0};
    assign ge = r2 >= {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k] <= ge ? 24'(r2 - {1'b0, d_q[k-1]}) : r2[23:0];
        d_q[k]   <= d_q[k-1];
        q_q[k]   <= {q_q[k-1][14:0], ge};
        lo_q[k]  <= lo_q[k-1];
        hi_q[k]  <= hi_q[k-1];
        ba_q[k]  <= ba_q[k-1];
      end
    end
  end

  // Normalized depth and the depth base.
  logic [16:0] z;
  logic [32:0] zs;
  logic [16:0] bz_q, bza_q;
  always_comb begin
    if (lo_q[Div])      z = '0;
    else if (hi_q[Div]) z = 17'h10000;
    else                z = {1'b0, q_q[Div]};
  end
  assign zs = 33'(z) * 33'(scale_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      bz_q  <= 17'h10000 - zs[32:16];
      bza_q <= ba_q[Div];
    end
  end

  // Logarithms of both bases.
  logic signed [21:0] la, lz;
  oitw_log2 u_log_a (.clk_i(clk_i), .en_i(en), .x_i(bza_q), .l_o(la));
  oitw_log2 u_log_z (.clk_i(clk_i), .en_i(en), .x_i(bz_q),  .l_o(lz));

  // Exponent times logarithm, floored to Q16.
  logic signed [38:0] pa, pz;
  logic signed [25:0] ya_q, yz_q;
  assign pa = $signed({1'b0, aexp_q}) * la;
  assign pz = $signed({1'b0, zexp_q}) * lz;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ya_q <= pa[37:12];
      yz_q <= pz[37:12];
    end
  end

  // Powers; both stay below 2^17 because the bases are near or below one.
  logic [32:0] ra, rz;
  oitw_exp2 u_exp_a (.clk_i(clk_i), .en_i(en), .y_i(ya_q), .r_o(ra));
  oitw_exp2 u_exp_z (.clk_i(clk_i), .en_i(en), .y_i(yz_q), .r_o(rz));

  // Weight product in two multiplier stages.
  logic [26:0] am_q;
  logic [16:0] zf_q;
  logic [43:0] wp;
  logic [23:0] wr_q;
  assign wp = 44'(am_q) * 44'(zf_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      am_q <= 27'(ra[16:0]) * 27'd1000;
      zf_q <= rz[16:0];
      wr_q <= wp[43:20];
    end
  end

  // Mode select and clamp into the output register.
  logic [23:0] wa, wa_lo, w_d, out_q;
  assign wa    = {11'b0, side_q[Lat-2].w_alpha};
  assign wa_lo = (wa < min_q) ? min_q : wa;

  always_comb begin
    if (mode_q == oitw_pkg::ModeAlphaRef) begin
      w_d = (wa_lo > max_q) ? max_q : wa_lo;
    end else if (wr_q < min_q) begin
      w_d = min_q;
    end else if (wr_q > max_q) begin
      w_d = max_q;
    end else begin
      w_d = wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= w_d;
  end

  assign weight_o    = out_q;
  assign out_valid_o = side_q[Lat-1].valid;

endmodule

[design/oitw_chk.sv]
// ----------------------------------------------------------------------------
// oitw_chk: port-level checks of the fragment weight block
// Watches the handshakes over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module oitw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] weight_o
);

  // The input stalls only while a finished beat waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output beat");

  // A blocked output beat must hold the input back, or a beat is lost.
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output beat blocked");

  // A stalled output beat keeps its weight.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(weight_o)))
    else $error("stalled output beat changed");

  // No result is shown while reset is held.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind oit_fragment_weight oitw_chk u_oitw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .weight_o    (weight_o)
);
